// ===== rtl/pid_position_regulator_macros.svh =====
// assertion macros for the pid position regulator
// used by the top level only, no other dependencies
`ifndef PID_POSITION_REGULATOR_MACROS_SVH
`define PID_POSITION_REGULATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPR_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PPR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ppr_pkg.sv =====
// shared constants and codes for the pid position regulator
// no dependencies
`default_nettype none

package ppr_pkg;

	localparam int FRAC_BITS_DEF      = 16;
	localparam int INTEGRAL_WIDTH_DEF = 48;

	localparam int SAMPLE_W    = 32;
	localparam int DRIVE_W     = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int GAIN_W      = 32;
	localparam int LIMIT_W     = 31;
	localparam int COUNT_W     = 4;
	localparam int MODE_W      = 2;
	localparam int ERR_W       = 33;

	// operating modes, code 3 behaves as drive pid
	localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIXED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TURN  = 2'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_TARGET    = 3'd1,
		REG_GAIN_P    = 3'd2,
		REG_GAIN_I    = 3'd3,
		REG_GAIN_D    = 3'd4,
		REG_INT_LIMIT = 3'd5,
		REG_TOLERANCE = 3'd6,
		REG_SETTLE    = 3'd7
	} reg_index_t;

	// register reset values
	localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 32'd3932160;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 32'd45875;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 32'd65536;
	localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 31'd2621440;
	localparam logic [LIMIT_W-1:0] TOLERANCE_RST = 31'd3277;
	localparam logic [COUNT_W-1:0] SETTLE_RST    = 4'd1;

	localparam int FULL_DRIVE = 25600;
	localparam int FOLD_DEG   = 350;
	localparam int TURN_DEG   = 360;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/ppr_if.sv =====
// valid/ready channel interfaces: sample input, result output, config writes
// depends on ppr_pkg for field widths
`default_nettype none

interface ppr_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  action;
	logic signed [ppr_pkg::SAMPLE_W-1:0]   sample_a;
	logic signed [ppr_pkg::SAMPLE_W-1:0]   sample_b;

	modport source (output valid, action, sample_a, sample_b, input ready);
	modport sink (input valid, action, sample_a, sample_b, output ready);
endinterface

interface ppr_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ppr_pkg::DRIVE_W-1:0]    left_drive;
	logic signed [ppr_pkg::DRIVE_W-1:0]    right_drive;
	logic                                  settled;

	modport source (output valid, left_drive, right_drive, settled, input ready);
	modport sink (input valid, left_drive, right_drive, settled, output ready);
endinterface

interface ppr_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [ppr_pkg::CFG_INDEX_W-1:0]       index;
	logic [ppr_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pid_position_regulator.sv =====
// pid position regulator: throughput one transaction per cycle unless result.ready
// stalls the output; the stage-2 integral and settle update keeps pace, and the
// stage-3 multipliers and stage-4 adder are fully pipelined
// arst_n clears the pipeline, the integral, previous error, settle state and loads
// register reset values; no clearing pass is needed after reset
// depends on ppr_pkg, ppr_if.sv and pid_position_regulator_macros.svh
`default_nettype none

module pid_position_regulator #(
	parameter int FRAC_BITS      = ppr_pkg::FRAC_BITS_DEF,
	parameter int INTEGRAL_WIDTH = ppr_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ppr_cfg_if.sink       cfg,
	ppr_sample_if.sink    sample,
	ppr_result_if.source  result
);

	// widths
	localparam int SW     = ppr_pkg::SAMPLE_W;
	localparam int EW     = ppr_pkg::ERR_W;
	localparam int READ_W = EW + 2;              // room for fold constants at wide fractions
	localparam int IW     = INTEGRAL_WIDTH;
	localparam int IH_W   = IW - 32;             // upper integral slice for split product
	localparam int GW     = ppr_pkg::GAIN_W;
	localparam int PE_W   = GW + 1 + EW;
	localparam int PD_W   = GW + 1 + EW + 1;
	localparam int PL_W   = 2 * GW;
	localparam int PH_W   = GW + 1 + IH_W;
	localparam int SUM_W  = IW + 35;
	localparam int SHIFT  = 2 * FRAC_BITS - 8;   // q(2f) down to q8.8
	localparam int DW     = ppr_pkg::DRIVE_W;
	localparam int CW     = ppr_pkg::COUNT_W;

	localparam logic signed [READ_W-1:0] FOLD_LIM = READ_W'(ppr_pkg::FOLD_DEG) << FRAC_BITS;
	localparam logic signed [READ_W-1:0] TURN_OFS = READ_W'(ppr_pkg::TURN_DEG) << FRAC_BITS;
	localparam logic signed [IW-1:0]     IMAX     = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0]     IMIN     = {1'b1, {(IW-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]  FULL_POS = SUM_W'(ppr_pkg::FULL_DRIVE);
	localparam logic signed [SUM_W-1:0]  FULL_NEG = -FULL_POS;
	localparam logic signed [DW-1:0]     DRV_POS  = DW'(ppr_pkg::FULL_DRIVE);
	localparam logic signed [DW-1:0]     DRV_NEG  = -DRV_POS;

	// ------------------------------------------------------------------
	// configuration registers, always ready
	// ------------------------------------------------------------------
	logic [ppr_pkg::MODE_W-1:0]  mode_q;
	logic signed [SW-1:0]        target_q;
	logic [GW-1:0]               gain_p_q;
	logic [GW-1:0]               gain_i_q;
	logic [GW-1:0]               gain_d_q;
	logic [ppr_pkg::LIMIT_W-1:0] int_limit_q;
	logic [ppr_pkg::LIMIT_W-1:0] tolerance_q;
	logic [CW-1:0]               settle_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= ppr_pkg::MODE_DRIVE;
			target_q       <= '0;
			gain_p_q       <= ppr_pkg::GAIN_P_RST;
			gain_i_q       <= ppr_pkg::GAIN_I_RST;
			gain_d_q       <= ppr_pkg::GAIN_D_RST;
			int_limit_q    <= ppr_pkg::INT_LIMIT_RST;
			tolerance_q    <= ppr_pkg::TOLERANCE_RST;
			settle_count_q <= ppr_pkg::SETTLE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				ppr_pkg::REG_MODE:      mode_q         <= cfg.data[ppr_pkg::MODE_W-1:0];
				ppr_pkg::REG_TARGET:    target_q       <= $signed(cfg.data[SW-1:0]);
				ppr_pkg::REG_GAIN_P:    gain_p_q       <= cfg.data[GW-1:0];
				ppr_pkg::REG_GAIN_I:    gain_i_q       <= cfg.data[GW-1:0];
				ppr_pkg::REG_GAIN_D:    gain_d_q       <= cfg.data[GW-1:0];
				ppr_pkg::REG_INT_LIMIT: int_limit_q    <= cfg.data[ppr_pkg::LIMIT_W-1:0];
				ppr_pkg::REG_TOLERANCE: tolerance_q    <= cfg.data[ppr_pkg::LIMIT_W-1:0];
				ppr_pkg::REG_SETTLE:    settle_count_q <= cfg.data[CW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline flow control: each stage loads when empty or when its
	// content moves on, so bubbles collapse while the output waits
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || result.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: input register, reading and error
	// ------------------------------------------------------------------
	logic                action_s1;
	logic signed [SW-1:0] a_s1, b_s1;

	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			action_s1 <= sample.action;
			a_s1      <= sample.sample_a;
			b_s1      <= sample.sample_b;
		end
	end

	logic signed [SW:0]     sum_ab, a_ext, mag_a;
	logic signed [READ_W-1:0] reading, err_full;

	always_comb begin
		sum_ab = {a_s1[SW-1], a_s1} + {b_s1[SW-1], b_s1};
		a_ext  = {a_s1[SW-1], a_s1};
		mag_a  = a_ext[SW] ? -a_ext : a_ext;
		if (mode_q == ppr_pkg::MODE_TURN) begin
			// headings past the fold point wrap to the negative side
			if ($signed({2'b00, mag_a}) > FOLD_LIM) begin
				reading = $signed({2'b00, mag_a}) - TURN_OFS;
			end else begin
				reading = READ_W'(a_s1);
			end
		end else begin
			// floor of the two-encoder average
			reading = READ_W'($signed(sum_ab[SW:1]));
		end
		err_full = READ_W'(target_q) - reading;
	end

	// ------------------------------------------------------------------
	// stage 2: integral, derivative and settle tracking (loop state)
	// ------------------------------------------------------------------
	logic                        action_s2;
	logic signed [EW-1:0]        err_s2;
	logic [ppr_pkg::MODE_W-1:0]  mode_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			action_s2 <= action_s1;
			err_s2    <= err_full[EW-1:0];
			mode_s2   <= mode_q;
		end
	end

	logic signed [IW-1:0] integral_q;
	logic signed [EW-1:0] last_error_q;
	logic [CW-1:0]        settle_cnt_q;
	logic                 finished_q;

	logic [EW-1:0]        aerr;
	logic signed [IW:0]   isum;
	logic signed [IW-1:0] int_sat, int_next;
	logic signed [EW:0]   deriv;
	logic                 cnt_inc;
	logic [CW-1:0]        cnt_next;
	logic                 done_now;
	logic                 commit2;

	always_comb begin
		aerr = err_s2[EW-1] ? (EW'(0) - err_s2) : err_s2;
		isum = {integral_q[IW-1], integral_q} + {{(IW+1-EW){err_s2[EW-1]}}, err_s2};
		// saturate on overflow of the integral width
		if (isum[IW] != isum[IW-1]) begin
			int_sat = isum[IW] ? IMIN : IMAX;
		end else begin
			int_sat = isum[IW-1:0];
		end
		// anti-windup: clear on zero error or large error
		if (err_s2 == '0 || aerr > {2'b00, int_limit_q}) begin
			int_next = '0;
		end else begin
			int_next = int_sat;
		end
		deriv    = {err_s2[EW-1], err_s2} - {last_error_q[EW-1], last_error_q};
		cnt_inc  = (aerr < {2'b00, tolerance_q}) && (settle_cnt_q != ppr_pkg::COUNT_MAX);
		cnt_next = settle_cnt_q + {{(CW-1){1'b0}}, cnt_inc};
		done_now = cnt_next >= settle_count_q;
	end

	assign commit2 = v_s2 && en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			last_error_q <= '0;
			settle_cnt_q <= '0;
			finished_q   <= 1'b0;
		end else if (commit2) begin
			if (!action_s2) begin
				// start of a move
				integral_q   <= '0;
				settle_cnt_q <= '0;
				finished_q   <= 1'b0;
				last_error_q <= EW'(target_q);
			end else if (!finished_q) begin
				integral_q   <= int_next;
				last_error_q <= err_s2;
				settle_cnt_q <= cnt_next;
				if (done_now) finished_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 3: gain products, integral product split at bit 32
	// ------------------------------------------------------------------
	logic                        zero_s3, settled_s3;
	logic signed [EW-1:0]        err_s3;
	logic signed [IW-1:0]        int_s3;
	logic signed [EW:0]          deriv_s3;
	logic [ppr_pkg::MODE_W-1:0]  mode_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			zero_s3    <= !action_s2 || finished_q;
			settled_s3 <= action_s2 && (finished_q || done_now);
			err_s3     <= err_s2;
			int_s3     <= int_next;
			deriv_s3   <= deriv;
			mode_s3    <= mode_s2;
		end
	end

	logic signed [PE_W-1:0] p_e;
	logic signed [PD_W-1:0] p_d;
	logic [PL_W-1:0]        p_il;
	logic signed [PH_W-1:0] p_ih;
	logic signed [IH_W-1:0] int_hi;

	always_comb begin
		int_hi = int_s3[IW-1:32];
		p_e    = PE_W'($signed({1'b0, gain_p_q})) * PE_W'(err_s3);
		p_d    = PD_W'($signed({1'b0, gain_d_q})) * PD_W'(deriv_s3);
		p_il   = PL_W'(gain_i_q) * PL_W'(int_s3[31:0]);
		p_ih   = PH_W'($signed({1'b0, gain_i_q})) * PH_W'(int_hi);
	end

	// ------------------------------------------------------------------
	// stage 4: sum of partial products in q(2f)
	// ------------------------------------------------------------------
	logic                        zero_s4, settled_s4;
	logic [ppr_pkg::MODE_W-1:0]  mode_s4;
	logic signed [PE_W-1:0]      p_e_s4;
	logic signed [PD_W-1:0]      p_d_s4;
	logic [PL_W-1:0]             p_il_s4;
	logic signed [PH_W-1:0]      p_ih_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			zero_s4    <= zero_s3;
			settled_s4 <= settled_s3;
			mode_s4    <= mode_s3;
			p_e_s4     <= p_e;
			p_d_s4     <= p_d;
			p_il_s4    <= p_il;
			p_ih_s4    <= p_ih;
		end
	end

	logic signed [SUM_W-1:0] e_ext, d_ext, il_ext, ih_ext, pid_sum;

	always_comb begin
		e_ext   = SUM_W'(p_e_s4);
		d_ext   = SUM_W'(p_d_s4);
		il_ext  = $signed(SUM_W'(p_il_s4));
		ih_ext  = SUM_W'(p_ih_s4) <<< 32;
		pid_sum = e_ext + d_ext + il_ext + ih_ext;
	end

	// ------------------------------------------------------------------
	// stage 5: floor to q8.8, clamp, mode selection
	// ------------------------------------------------------------------
	logic                        zero_s5, settled_s5;
	logic [ppr_pkg::MODE_W-1:0]  mode_s5;
	logic signed [SUM_W-1:0]     sum_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			zero_s5    <= zero_s4;
			settled_s5 <= settled_s4;
			mode_s5    <= mode_s4;
			sum_s5     <= pid_sum;
		end
	end

	logic signed [SUM_W-1:0] sum_q88;
	logic signed [DW-1:0]    pid_drv, left_c, right_c;

	always_comb begin
		// arithmetic shift is a floor; clamp bounds are exact multiples
		sum_q88 = sum_s5 >>> SHIFT;
		if (sum_q88 >= FULL_POS) begin
			pid_drv = DRV_POS;
		end else if (sum_q88 < FULL_NEG) begin
			pid_drv = DRV_NEG;
		end else begin
			pid_drv = sum_q88[DW-1:0];
		end
		if (zero_s5) begin
			left_c  = '0;
			right_c = '0;
		end else if (mode_s5 == ppr_pkg::MODE_FIXED) begin
			left_c  = (target_q > 0) ? DRV_POS : DRV_NEG;
			right_c = left_c;
		end else if (mode_s5 == ppr_pkg::MODE_TURN) begin
			left_c  = pid_drv;
			right_c = -pid_drv;
		end else begin
			left_c  = pid_drv;
			right_c = pid_drv;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: output register
	// ------------------------------------------------------------------
	logic signed [DW-1:0] left_s6, right_s6;
	logic                 settled_s6;

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			left_s6    <= left_c;
			right_s6   <= right_c;
			settled_s6 <= settled_s5;
		end
	end

	assign result.valid       = v_s6;
	assign result.left_drive  = left_s6;
	assign result.right_drive = right_s6;
	assign result.settled     = settled_s6;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
`include "pid_position_regulator_macros.svh"

	// a start transaction leaves a fresh move behind it
	`PPR_ASSERT_NEXT(a_start_clears, clk, arst_n, commit2 && !action_s2,
		integral_q == '0 && settle_cnt_q == '0 && !finished_q, "start did not clear state")

	// samples after the move finished leave the loop state untouched
	`PPR_ASSERT_NEXT(a_finished_holds, clk, arst_n, commit2 && action_s2 && finished_q,
		$stable(integral_q) && $stable(last_error_q) && $stable(settle_cnt_q),
		"state changed after finish")

	// drives stay within full scale
	`PPR_ASSERT_NOW(a_drive_range, clk, arst_n, v_s6,
		left_s6 <= DRV_POS && left_s6 >= DRV_NEG && right_s6 <= DRV_POS && right_s6 >= DRV_NEG,
		"drive out of range")

endmodule

`default_nettype wire
